@@ rtl/compass_frame_decode_filter_core_macros.svh @@
// Assertion macros for the compass frame decode filter core.
// No dependencies; included by the top level only.
`ifndef COMPASS_FRAME_DECODE_FILTER_CORE_MACROS_SVH
`define COMPASS_FRAME_DECODE_FILTER_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define CFDF_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define CFDF_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/cfdf_pkg.sv @@
// Shared types and constants for the compass frame decode filter core.
// No dependencies.
package cfdf_pkg;

   localparam int ANGLE_W = 19;
   localparam int WSUM_W  = 23;
   localparam int MAG_W   = 22;
   localparam int DIV_SHIFT = 26;
   localparam int RECIP_W = 23;
   // ceil(2^26 / 13); exact floor(n/13) for every n below 2^22
   localparam logic [RECIP_W-1:0] DIV13_RECIP = 23'd5162221;

   typedef logic signed [ANGLE_W-1:0] angle_type;
   typedef logic signed [WSUM_W-1:0]  wsum_type;

   // One checked frame, as handed from the byte assembler to the filter.
   typedef struct packed {
      logic       ok;
      logic [7:0] d2;
      logic [7:0] d3;
      logic [7:0] d4;
      logic [7:0] d6;
   } frame_beat_type;

   // Updated angle plus undivided weighted history sum.
   typedef struct packed {
      logic      ok;
      angle_type angle;
      wsum_type  wsum;
   } sum_beat_type;

endpackage

@@ rtl/cfdf_frame.sv @@
// Byte assembler: counts bytes into 8-byte frames, checks header and checksum.
// Depends on cfdf_pkg.
module cfdf_frame (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [7:0]              req_rx_byte,
   output logic                    frame_valid,
   input  logic                    frame_ready,
   output cfdf_pkg::frame_beat_type frame_beat
);
   import cfdf_pkg::*;

   localparam logic [2:0] POS_HDR0 = 3'd0;
   localparam logic [2:0] POS_HDR1 = 3'd1;
   localparam logic [2:0] POS_D2   = 3'd2;
   localparam logic [2:0] POS_D3   = 3'd3;
   localparam logic [2:0] POS_D4   = 3'd4;
   localparam logic [2:0] POS_D6   = 3'd6;
   localparam logic [2:0] POS_CHK  = 3'd7;
   localparam logic [7:0] HDR0 = 8'h0D;
   localparam logic [7:0] HDR1 = 8'h0A;

   logic [2:0]     pos_ff, pos_in;
   logic           fv_ff, fv_in;
   logic [7:0]     sum_ff, sum_in;
   logic           hdr0_ff, hdr0_in;
   logic           hdr_ok_ff, hdr_ok_in;
   logic [7:0]     d2_ff, d2_in, d3_ff, d3_in, d4_ff, d4_in, d6_ff, d6_in;
   frame_beat_type frame_ff, frame_in;
   logic           accept;

   assign req_ready   = !fv_ff || frame_ready;
   assign accept      = req_valid && req_ready;
   assign frame_valid = fv_ff;
   assign frame_beat  = frame_ff;

   always_comb begin
      pos_in    = pos_ff;
      fv_in     = fv_ff && !frame_ready;
      sum_in    = sum_ff;
      hdr0_in   = hdr0_ff;
      hdr_ok_in = hdr_ok_ff;
      d2_in     = d2_ff;
      d3_in     = d3_ff;
      d4_in     = d4_ff;
      d6_in     = d6_ff;
      frame_in  = frame_ff;
      if (accept) begin
         pos_in = pos_ff + 3'd1;
         sum_in = sum_ff + req_rx_byte;
         case (pos_ff)
            POS_HDR0: begin
               sum_in  = req_rx_byte;
               hdr0_in = (req_rx_byte == HDR0);
            end
            POS_HDR1: hdr_ok_in = hdr0_ff && (req_rx_byte == HDR1);
            POS_D2:   d2_in = req_rx_byte;
            POS_D3:   d3_in = req_rx_byte;
            POS_D4:   d4_in = req_rx_byte;
            POS_D6:   d6_in = req_rx_byte;
            POS_CHK: begin
               fv_in       = 1'b1;
               frame_in.ok = hdr_ok_ff && (req_rx_byte == sum_ff);
               frame_in.d2 = d2_ff;
               frame_in.d3 = d3_ff;
               frame_in.d4 = d4_ff;
               frame_in.d6 = d6_ff;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
         fv_ff  <= 1'b0;
      end else begin
         pos_ff <= pos_in;
         fv_ff  <= fv_in;
      end
   end

   always_ff @(posedge clock) begin
      sum_ff    <= sum_in;
      hdr0_ff   <= hdr0_in;
      hdr_ok_ff <= hdr_ok_in;
      d2_ff     <= d2_in;
      d3_ff     <= d3_in;
      d4_ff     <= d4_in;
      d6_ff     <= d6_in;
      frame_ff  <= frame_in;
   end

endmodule

@@ rtl/cfdf_filter.sv @@
// Angle decode and four-deep history; registers the weighted history sum.
// Depends on cfdf_pkg.
module cfdf_filter (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     frame_valid,
   output logic                     frame_ready,
   input  cfdf_pkg::frame_beat_type frame_beat,
   output logic                     sum_valid,
   input  logic                     sum_ready,
   output cfdf_pkg::sum_beat_type   sum_beat
);
   import cfdf_pkg::*;

   localparam angle_type ASCII_ZERO = 19'sd48;
   localparam angle_type W1000 = 19'sd1000;
   localparam angle_type W100  = 19'sd100;
   localparam angle_type W10   = 19'sd10;
   localparam wsum_type  OLD_WEIGHT = 23'sd10;

   function automatic angle_type digit_val(input logic [7:0] b);
      digit_val = angle_type'({11'b0, b}) - ASCII_ZERO;
   endfunction

   angle_type    angle_ff, angle_in;
   angle_type    hist_ff [4];
   angle_type    hist_in [4];
   logic         sv_ff, sv_in;
   sum_beat_type sum_ff, sum_in;
   angle_type    decoded;
   logic         take;

   assign frame_ready = !sv_ff || sum_ready;
   assign take        = frame_valid && frame_ready;
   assign sum_valid   = sv_ff;
   assign sum_beat    = sum_ff;

   always_comb begin
      decoded = digit_val(frame_beat.d2) * W1000 + digit_val(frame_beat.d3) * W100
              + digit_val(frame_beat.d4) * W10 + digit_val(frame_beat.d6);
      angle_in = angle_ff;
      hist_in  = hist_ff;
      sv_in    = sv_ff && !sum_ready;
      sum_in   = sum_ff;
      if (take) begin
         angle_in   = frame_beat.ok ? decoded : angle_ff;
         hist_in[0] = hist_ff[1];
         hist_in[1] = hist_ff[2];
         hist_in[2] = hist_ff[3];
         hist_in[3] = angle_in;
         sv_in      = 1'b1;
         sum_in.ok    = frame_beat.ok;
         sum_in.angle = angle_in;
         // newest three once, oldest ten times
         sum_in.wsum  = wsum_type'(angle_in) + wsum_type'(hist_ff[3])
                      + wsum_type'(hist_ff[2]) + wsum_type'(hist_ff[1]) * OLD_WEIGHT;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         angle_ff <= '0;
         hist_ff  <= '{default: '0};
         sv_ff    <= 1'b0;
      end else begin
         angle_ff <= angle_in;
         hist_ff  <= hist_in;
         sv_ff    <= sv_in;
      end
   end

   always_ff @(posedge clock) begin
      sum_ff <= sum_in;
   end

endmodule

@@ rtl/cfdf_div13.sv @@
// Signed divide by 13, truncating toward zero, via reciprocal multiply.
// Holds the result register that drives the rsp_ channel. Depends on cfdf_pkg.
module cfdf_div13 (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   sum_valid,
   output logic                   sum_ready,
   input  cfdf_pkg::sum_beat_type sum_beat,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic                   rsp_frame_ok,
   output logic signed [18:0]     rsp_angle_tenths,
   output logic signed [18:0]     rsp_average_tenths
);
   import cfdf_pkg::*;

   localparam int PROD_W = MAG_W + RECIP_W;

   logic                rv_ff, rv_in;
   logic                ok_ff, ok_in;
   angle_type           angle_ff, angle_in;
   angle_type           avg_ff, avg_in;
   logic                neg;
   logic [MAG_W-1:0]    mag;
   logic [PROD_W-1:0]   prod;
   logic [ANGLE_W-1:0]  quot;
   logic                take;

   assign sum_ready          = !rv_ff || rsp_ready;
   assign take               = sum_valid && sum_ready;
   assign rsp_valid          = rv_ff;
   assign rsp_frame_ok       = ok_ff;
   assign rsp_angle_tenths   = angle_ff;
   assign rsp_average_tenths = avg_ff;

   always_comb begin
      neg  = sum_beat.wsum[WSUM_W-1];
      mag  = neg ? MAG_W'(-sum_beat.wsum) : MAG_W'(sum_beat.wsum);
      prod = PROD_W'(mag) * PROD_W'(DIV13_RECIP);
      quot = prod[PROD_W-1:DIV_SHIFT];
      rv_in    = rv_ff && !rsp_ready;
      ok_in    = ok_ff;
      angle_in = angle_ff;
      avg_in   = avg_ff;
      if (take) begin
         rv_in    = 1'b1;
         ok_in    = sum_beat.ok;
         angle_in = sum_beat.angle;
         avg_in   = neg ? angle_type'(-quot) : angle_type'(quot);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rv_ff <= 1'b0;
      end else begin
         rv_ff <= rv_in;
      end
   end

   always_ff @(posedge clock) begin
      ok_ff    <= ok_in;
      angle_ff <= angle_in;
      avg_ff   <= avg_in;
   end

endmodule

@@ rtl/compass_frame_decode_filter_core.sv @@
// Compass frame decode filter, top level: byte assembler, filter, divider.
// Depends on cfdf_pkg, cfdf_frame, cfdf_filter, cfdf_div13 and the macro header.
//
//  channel | ports                                   | dir | beat
//  --------+-----------------------------------------+-----+------------------------
//  req     | req_valid req_ready req_rx_byte         | in  | one received byte
//  rsp     | rsp_valid rsp_ready rsp_frame_ok        | out | one per eighth byte
//          | rsp_angle_tenths rsp_average_tenths     |     |
//
// One byte beat is accepted every cycle while req_ready is high. A frame
// result reaches rsp after its eighth byte is accepted, via the checksum/header
// register, the angle and weighted-sum register, then the divide-by-13
// reciprocal multiply into the output register. Each stage moves when its
// successor is empty or draining, so a stalled rsp backs up through the stages
// to req_ready. Synchronous active-high reset clears the byte count, current
// angle, history and all valid flags; frame byte storage needs no reset.
`include "compass_frame_decode_filter_core_macros.svh"

module compass_frame_decode_filter_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [7:0]         req_rx_byte,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic               rsp_frame_ok,
   output logic signed [18:0] rsp_angle_tenths,
   output logic signed [18:0] rsp_average_tenths
);
   import cfdf_pkg::*;

   // Frame beat: header/checksum verdict plus the four angle digits.
   logic           frame_valid;
   logic           frame_ready;
   frame_beat_type frame_beat;

   // Sum beat: updated angle plus weighted sum waiting for the divide.
   logic           sum_valid;
   logic           sum_ready;
   sum_beat_type   sum_beat;

   cfdf_frame u_frame (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_rx_byte (req_rx_byte),
      .frame_valid (frame_valid),
      .frame_ready (frame_ready),
      .frame_beat  (frame_beat)
   );

   // Angle update and history shift happen once per frame beat taken here.
   cfdf_filter u_filter (
      .clock       (clock),
      .reset       (reset),
      .frame_valid (frame_valid),
      .frame_ready (frame_ready),
      .frame_beat  (frame_beat),
      .sum_valid   (sum_valid),
      .sum_ready   (sum_ready),
      .sum_beat    (sum_beat)
   );

   cfdf_div13 u_div13 (
      .clock              (clock),
      .reset              (reset),
      .sum_valid          (sum_valid),
      .sum_ready          (sum_ready),
      .sum_beat           (sum_beat),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_frame_ok       (rsp_frame_ok),
      .rsp_angle_tenths   (rsp_angle_tenths),
      .rsp_average_tenths (rsp_average_tenths)
   );

   // A frame beat only appears right after a byte beat was taken.
   `CFDF_ASSERT_IMP(a_frame_from_byte, clock, reset, $rose(frame_valid), $past(req_valid && req_ready), "frame beat without byte beat")

   // A new result only appears right after a sum beat was held.
   `CFDF_ASSERT_IMP(a_rsp_from_sum, clock, reset, $rose(rsp_valid), $past(sum_valid), "result without sum beat")

   // The average is a weighted mean of in-range angles, so it stays in range.
   `CFDF_ASSERT_IMP(a_avg_range, clock, reset, rsp_valid, (rsp_average_tenths >= -19'sd53328) && (rsp_average_tenths <= 19'sd229977), "average out of range")

   // A full downstream stage with rsp stalled keeps the upstream frame beat waiting.
   `CFDF_ASSERT_NXT(a_stall_holds, clock, reset, frame_valid && sum_valid && rsp_valid && !rsp_ready, frame_valid, "frame beat lost under stall")

endmodule
